>>> design/tak_pkg.sv
// ----------------------------------------------------------------------------
// tak_pkg
// Widths and pipeline constants shared by the triangle area datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tak_pkg;

    localparam int COORD_W  = 16;                 // vertex coordinate
    localparam int DIFF_W   = 16;                 // |coordinate difference|
    localparam int SQ_W     = 33;                 // dx^2 + dy^2
    localparam int SRAD_W   = 50;                 // side radicand, padded even
    localparam int LEN_W    = SRAD_W / 2;         // side length, Q.8
    localparam int FAC_W    = 27;                 // Heron factor, Q.8
    localparam int PROD_W   = 2 * FAC_W;          // pair product
    localparam int HALF_W   = FAC_W;              // split point of pair product
    localparam int ARAD_W   = 2 * PROD_W;         // full product, Q.32
    localparam int ROOT_W   = ARAD_W / 2;         // sqrt of product, Q.16 * 4
    localparam int AREA_W   = 48;

    // Register stages from input beat to result strobe.
    localparam int LATENCY  = 2 + LEN_W + 5 + ROOT_W + 1;

    typedef logic [LEN_W-1:0] t_len;
    typedef logic [FAC_W-1:0] t_fac;

endpackage

`default_nettype wire

>>> design/tak_isqrt.sv
// ----------------------------------------------------------------------------
// tak_isqrt
// Pipelined integer square root, floor, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tak_isqrt #(
    parameter int W = 50
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [W-1:0]   i_rad,
    output logic                o_valid,
    output logic [W/2-1:0]      o_root
);

    localparam int N  = W / 2;
    localparam int RW = N + 3;

    logic          r_vld [N];
    logic [RW-1:0] r_rem [N];
    logic [N-1:0]  r_q   [N];
    logic [W-1:0]  r_rad [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic          p_vld;
        logic [RW-1:0] p_rem;
        logic [N-1:0]  p_q;
        logic [W-1:0]  p_rad;
        logic [RW-1:0] n_cur;
        logic [RW-1:0] n_trial;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_rem = '0;
            assign p_q   = '0;
            assign p_rad = i_rad;
        end else begin : g_next
            assign p_vld = r_vld[k-1];
            assign p_rem = r_rem[k-1];
            assign p_q   = r_q[k-1];
            assign p_rad = r_rad[k-1];
        end

        // bring down two radicand bits, try (2q)*2 + 1
        assign n_cur   = {p_rem[RW-3:0], p_rad[W-1:W-2]};
        assign n_trial = {1'b0, p_q, 2'b01};
        assign n_ge    = (n_cur >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
            r_rem[k] <= n_ge ? (n_cur - n_trial) : n_cur;
            r_q[k]   <= {p_q[N-2:0], n_ge};
            r_rad[k] <= {p_rad[W-3:0], 2'b00};
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_q[N-1];

endmodule

`default_nettype wire

>>> design/triangle_area_kahan_top.sv
// Triangle area, Kahan's stable Heron form, fixed point.
// Throughput: one triangle per cycle; busy is always low.
// The depth is set by the two digit-serial square roots (25 and 54 stages).
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// triangle_area_kahan_top
// Side lengths, descending sort, clamped factors, product and root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_area_kahan_top
    import tak_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [COORD_W-1:0]  i_ax,
    input  wire logic signed [COORD_W-1:0]  i_ay,
    input  wire logic signed [COORD_W-1:0]  i_bx,
    input  wire logic signed [COORD_W-1:0]  i_by_coord,
    input  wire logic signed [COORD_W-1:0]  i_cx,
    input  wire logic signed [COORD_W-1:0]  i_cy,
    output logic                            o_valid,
    output logic [AREA_W-1:0]               o_area_q16
);

    assign busy = 1'b0;

    // ---------------- stage 1: absolute differences
    function automatic logic [DIFF_W-1:0] absdiff(logic signed [COORD_W-1:0] p,
                                                  logic signed [COORD_W-1:0] q);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = COORD_W'(1) == 0 ? '0 : ({p[COORD_W-1], p} - {q[COORD_W-1], q});
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[DIFF_W-1:0];
    endfunction

    logic              r1_vld;
    logic [DIFF_W-1:0] r1_dx [3];
    logic [DIFF_W-1:0] r1_dy [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        r1_dx[0] <= absdiff(i_bx, i_ax);
        r1_dy[0] <= absdiff(i_by_coord, i_ay);
        r1_dx[1] <= absdiff(i_bx, i_cx);
        r1_dy[1] <= absdiff(i_by_coord, i_cy);
        r1_dx[2] <= absdiff(i_cx, i_ax);
        r1_dy[2] <= absdiff(i_cy, i_ay);
    end

    // ---------------- stage 2: squared lengths
    logic            r2_vld;
    logic [SQ_W-1:0] r2_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int i = 0; i < 3; i++) begin
            r2_sq[i] <= (SQ_W'(r1_dx[i]) * SQ_W'(r1_dx[i]))
                      + (SQ_W'(r1_dy[i]) * SQ_W'(r1_dy[i]));
        end
    end

    // ---------------- side roots: floor(sqrt(sq * 2^16))
    logic s_vld [3];
    t_len s_len [3];

    for (genvar i = 0; i < 3; i++) begin : g_side
        tak_isqrt #(.W(SRAD_W)) u_side (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r2_vld),
            .i_rad   ({1'b0, r2_sq[i], 16'h0000}),
            .o_valid (s_vld[i]),
            .o_root  (s_len[i])
        );
    end

    // ---------------- stage 3: sort descending
    logic r3_vld;
    t_len r3_a, r3_b, r3_c;

    always_ff @(posedge i_clk) begin
        t_len a, b, c, t;
        a = s_len[0];
        b = s_len[1];
        c = s_len[2];
        if (a < b) begin t = a; a = b; b = t; end
        if (a < c) begin t = a; a = c; c = t; end
        if (b < c) begin t = b; b = c; c = t; end
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= s_vld[0] & s_vld[1] & s_vld[2];
        end
        r3_a <= a;
        r3_b <= b;
        r3_c <= c;
    end

    // ---------------- stage 4: factors, clamped at zero
    function automatic t_fac clamp0(logic signed [FAC_W:0] v);
        return v[FAC_W] ? '0 : v[FAC_W-1:0];
    endfunction

    logic r4_vld;
    t_fac r4_f [4];

    always_ff @(posedge i_clk) begin
        logic signed [FAC_W:0] a, b, c;
        a = (FAC_W+1)'(r3_a);
        b = (FAC_W+1)'(r3_b);
        c = (FAC_W+1)'(r3_c);
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_f[0] <= clamp0(a + (b + c));
        r4_f[1] <= clamp0(c - (a - b));
        r4_f[2] <= clamp0(c + (a - b));
        r4_f[3] <= clamp0(a + (b - c));
    end

    // ---------------- stage 5: pair products
    logic              r5_vld;
    logic [PROD_W-1:0] r5_p12, r5_p34;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_p12 <= PROD_W'(r4_f[0]) * PROD_W'(r4_f[1]);
        r5_p34 <= PROD_W'(r4_f[2]) * PROD_W'(r4_f[3]);
    end

    // ---------------- stage 6: partial products of the wide multiply
    logic              r6_vld;
    logic [PROD_W-1:0] r6_ll, r6_lh, r6_hl, r6_hh;

    always_ff @(posedge i_clk) begin
        logic [HALF_W-1:0] xl, xh, yl, yh;
        xl = r5_p12[HALF_W-1:0];
        xh = r5_p12[PROD_W-1:HALF_W];
        yl = r5_p34[HALF_W-1:0];
        yh = r5_p34[PROD_W-1:HALF_W];
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_ll <= PROD_W'(xl) * PROD_W'(yl);
        r6_lh <= PROD_W'(xl) * PROD_W'(yh);
        r6_hl <= PROD_W'(xh) * PROD_W'(yl);
        r6_hh <= PROD_W'(xh) * PROD_W'(yh);
    end

    // ---------------- stage 7: assemble product
    logic              r7_vld;
    logic [ARAD_W-1:0] r7_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_prod <= (ARAD_W'(r6_hh) << (2 * HALF_W))
                 + ((ARAD_W'(r6_lh) + ARAD_W'(r6_hl)) << HALF_W)
                 + ARAD_W'(r6_ll);
    end

    // ---------------- area root
    logic              a_vld;
    logic [ROOT_W-1:0] a_root;

    tak_isqrt #(.W(ARAD_W)) u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_vld),
        .i_rad   (r7_prod),
        .o_valid (a_vld),
        .o_root  (a_root)
    );

    // ---------------- output register: divide by four
    logic              r_out_vld;
    logic [AREA_W-1:0] r_out_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= a_vld;
        end
        r_out_area <= a_root[AREA_W+1:2];
    end

    assign o_valid    = r_out_vld;
    assign o_area_q16 = r_out_area;

endmodule

`default_nettype wire

>>> design/tak_checker.sv
// ----------------------------------------------------------------------------
// tak_checker
// Port-level checks on the triangle area pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tak_checker
    import tak_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic signed [COORD_W-1:0]  i_ax,
    input  wire logic signed [COORD_W-1:0]  i_ay,
    input  wire logic signed [COORD_W-1:0]  i_bx,
    input  wire logic signed [COORD_W-1:0]  i_by_coord,
    input  wire logic                       o_valid,
    input  wire logic [AREA_W-1:0]          o_area_q16
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_valid_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching start beat");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

    a_coincident_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_ax == i_bx && i_ay == i_by_coord, LATENCY)
            |-> o_area_q16 == '0)
        else $error("coincident vertices gave nonzero area");

endmodule

bind triangle_area_kahan_top tak_checker u_tak_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_ax       (i_ax),
    .i_ay       (i_ay),
    .i_bx       (i_bx),
    .i_by_coord (i_by_coord),
    .o_valid    (o_valid),
    .o_area_q16 (o_area_q16)
);

`default_nettype wire
